/* design/sol_pkg.sv */
// shared types and constants for the source offset line locator
`timescale 1ns / 1ps
package sol_pkg;

  // default table sizes and offset width
  localparam int MAX_FILES_DEF   = 16;
  localparam int MAX_LINES_DEF   = 4096;
  localparam int OFFSET_BITS_DEF = 32;

  // fixed field widths of the channels
  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int OFS_W    = 32;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 4;
  localparam int LINE_W   = 13;
  localparam int COL_W    = 32;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = 2;
  localparam int QC_W        = 3;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_END,
    OP_QUERY
  } op_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND   = 2'd0,
    ST_INVALID = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  // classified operation handed from front to back
  typedef struct packed {
    op_kind_t         kind;
    logic             newline;
    logic [OFS_W-1:0] query;
    logic             loc_valid;
  } op_t;

endpackage

/* design/sol_if.sv */
// channel interfaces: input items, results and configuration writes
`timescale 1ns / 1ps
interface sol_item_if;
  import sol_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_byte;
  logic [OFS_W-1:0]  query_offset;
  logic              location_valid;

  modport source (output valid, mode, data_byte, query_offset, location_valid,
                  input ready);
  modport sink   (input valid, mode, data_byte, query_offset, location_valid,
                  output ready);
endinterface

interface sol_result_if;
  import sol_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIDX_W-1:0]   file_index;
  logic [LINE_W-1:0]   line_number;
  logic [COL_W-1:0]    column_number;
  logic                table_overflow;

  modport source (output valid, status, file_index, line_number, column_number,
                  table_overflow, input ready);
  modport sink   (input valid, status, file_index, line_number, column_number,
                  table_overflow, output ready);
endinterface

interface sol_cfg_if;
  import sol_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/sol_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

/* design/sol_front.sv */
// front end: accepts input beats, decodes the mode and queues operations
`timescale 1ns / 1ps
module sol_front (
  sol_item_if.sink       item,
  output logic           push,
  output sol_pkg::op_t   push_op,
  input  logic           full
);
  import sol_pkg::*;

  // accept whenever the queue has room; unused mode is dropped here
  assign item.ready = !full;

  // classify the beat
  always_comb begin
    push              = 1'b0;
    push_op.kind      = OP_BYTE;
    push_op.newline   = (item.data_byte == NEWLINE);
    push_op.query     = item.query_offset;
    push_op.loc_valid = item.location_valid;
    case (item.mode)
      MODE_BYTE: begin
        push         = item.valid && !full;
        push_op.kind = OP_BYTE;
      end
      MODE_END: begin
        push         = item.valid && !full;
        push_op.kind = OP_END;
      end
      MODE_QUERY: begin
        push         = item.valid && !full;
        push_op.kind = OP_QUERY;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end
endmodule

/* design/sol_queue.sv */
// short fifo of classified operations between front and back
`timescale 1ns / 1ps
module sol_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sol_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output sol_pkg::op_t head,
  output logic         empty
);
  import sol_pkg::*;

  op_t             slots [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;

  assign full  = (count == QC_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

/* design/sol_back.sv */
// back end: table updates for loads and the two binary searches for queries
`timescale 1ns / 1ps
module sol_back #(
  parameter int MAX_FILES   = sol_pkg::MAX_FILES_DEF,
  parameter int MAX_LINES   = sol_pkg::MAX_LINES_DEF,
  parameter int OFFSET_BITS = sol_pkg::OFFSET_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  sol_cfg_if.sink        cfg,
  input  sol_pkg::op_t   head,
  input  logic           empty,
  output logic           pop,
  sol_result_if.source   result
);
  import sol_pkg::*;

  localparam int FCNT_W = $clog2(MAX_FILES + 1);
  localparam int FA_W   = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int LCNT_W = $clog2(MAX_LINES + 1);
  localparam int LA_W   = $clog2(MAX_LINES);
  localparam logic [FCNT_W-1:0] FILE_LIMIT = FCNT_W'(MAX_FILES);
  localparam logic [LCNT_W-1:0] LINE_LIMIT = LCNT_W'(MAX_LINES);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_OPEN  = 9'b000000010,
    S_LOAD  = 9'b000000100,
    S_FSRCH = 9'b000001000,
    S_FCHK  = 9'b000010000,
    S_FB    = 9'b000100000,
    S_LSRCH = 9'b001000000,
    S_LFIN  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // loader state
  logic [FCNT_W-1:0]      file_count;
  logic [LCNT_W-1:0]      line_count;
  logic [OFFSET_BITS-1:0] next_offset;
  logic [OFFSET_BITS-1:0] write_offset;
  logic                   file_open;
  logic                   overflow;

  // query working registers
  op_t                    op_r;
  logic [OFFSET_BITS-1:0] q_r;
  logic [FCNT_W-1:0]      flo, fhi, f_r;
  logic [LCNT_W-1:0]      l2, h2, a_r, line_r;
  logic [OFFSET_BITS-1:0] ls_r;
  logic                   use_cnt;
  status_t                status_r;

  // result register
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [FIDX_W-1:0]      out_file;
  logic [LINE_W-1:0]      out_line;
  logic [COL_W-1:0]       out_col;
  logic                   out_ovf;

  // ram ports
  logic                   fs_we, fe_we, ffl_we, ls_we;
  logic [FA_W-1:0]        f_waddr, f_raddr, ffl_raddr;
  logic [LA_W-1:0]        l_waddr, l_raddr;
  logic [OFFSET_BITS-1:0] l_wdata;
  logic [OFFSET_BITS-1:0] fs_rdata, fe_rdata, ls_rdata;
  logic [LCNT_W-1:0]      ffl_rdata;

  // load control
  op_t                    cur_op;
  logic                   exec_load;
  logic                   fc_room, line_room;
  logic                   push_req, push_ok, overflow_set;
  logic [OFFSET_BITS-1:0] wo_inc;

  // search arithmetic
  logic [FCNT_W-1:0]      f_mid, flo_n, fhi_n, f_nmid, f_p1;
  logic                   f_cmp, f_more;
  logic [LCNT_W-1:0]      l_mid, l2_n, h2_n, l_nmid, b_raw, b_eff, fb_mid;
  logic                   l_cmp, l_more;
  logic [OFFSET_BITS-1:0] col_diff;

  assign cfg.ready = 1'b1;
  assign pop       = (state == S_IDLE) && !empty;

  assign fc_room   = (file_count < FILE_LIMIT);
  assign line_room = (line_count < LINE_LIMIT);
  assign wo_inc    = write_offset + 1'b1;

  // current load: straight from the queue head when a file is open, else after the open step
  assign cur_op    = (state == S_LOAD) ? op_r : head;
  assign exec_load = (state == S_LOAD) ||
                     (pop && (head.kind != OP_QUERY) && file_open);

  // table writes
  always_comb begin
    fs_we    = 1'b0;
    fe_we    = 1'b0;
    ffl_we   = 1'b0;
    push_req = 1'b0;
    l_wdata  = wo_inc;
    if (state == S_OPEN) begin
      fs_we    = fc_room;
      ffl_we   = fc_room;
      push_req = fc_room;
      l_wdata  = next_offset;
    end else if (exec_load) begin
      case (cur_op.kind)
        OP_BYTE: push_req = cur_op.newline && fc_room;
        OP_END:  fe_we    = fc_room;
        default: push_req = 1'b0;
      endcase
    end
  end

  assign push_ok      = push_req && line_room;
  assign ls_we        = push_ok;
  assign overflow_set = (push_req && !line_room) || ((state == S_OPEN) && !fc_room);
  assign f_waddr      = file_count[FA_W-1:0];
  assign l_waddr      = line_count[LA_W-1:0];

  // file search step
  assign f_mid  = flo + ((fhi - flo) >> 1);
  assign f_cmp  = (q_r < fe_rdata);
  assign flo_n  = f_cmp ? flo : (f_mid + 1'b1);
  assign fhi_n  = f_cmp ? f_mid : fhi;
  assign f_more = (flo_n < fhi_n);
  assign f_nmid = flo_n + ((fhi_n - flo_n) >> 1);
  assign f_p1   = f_r + 1'b1;

  function automatic logic [FA_W-1:0] f_mid_start();
    logic [FCNT_W-1:0] half;
    half = file_count >> 1;
    return half[FA_W-1:0];
  endfunction

  always_comb begin
    case (state)
      S_FSRCH: f_raddr = f_more ? f_nmid[FA_W-1:0] : flo_n[FA_W-1:0];
      default: f_raddr = f_mid_start();
    endcase
    // upper line bound comes from the next file, or from the open file
    if (state == S_FCHK) begin
      ffl_raddr = (f_p1 < file_count) ? f_p1[FA_W-1:0] : file_count[FA_W-1:0];
    end else begin
      ffl_raddr = f_raddr;
    end
  end

  // line search step
  assign b_raw  = use_cnt ? line_count : ffl_rdata;
  assign b_eff  = (b_raw < a_r) ? a_r : b_raw;
  assign fb_mid = a_r + ((b_eff - a_r) >> 1);
  assign l_mid  = l2 + ((h2 - l2) >> 1);
  assign l_cmp  = (q_r < ls_rdata);
  assign l2_n   = l_cmp ? l2 : (l_mid + 1'b1);
  assign h2_n   = l_cmp ? l_mid : h2;
  assign l_more = (l2_n < h2_n);
  assign l_nmid = l2_n + ((h2_n - l2_n) >> 1);

  always_comb begin
    case (state)
      S_FB:    l_raddr = fb_mid[LA_W-1:0];
      S_LSRCH: l_raddr = l_more ? l_nmid[LA_W-1:0] : LA_W'(l2_n - 1'b1);
      default: l_raddr = l_mid[LA_W-1:0];
    endcase
  end

  assign col_diff = q_r - ls_r;

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      file_count   <= '0;
      line_count   <= '0;
      next_offset  <= '0;
      write_offset <= '0;
      file_open    <= 1'b0;
      overflow     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // a taken result beat empties the output register unless a new one lands
      if (result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      // shared load bookkeeping
      if (push_ok) begin
        line_count <= line_count + 1'b1;
      end
      if (overflow_set) begin
        overflow <= 1'b1;
      end
      if (fe_we) begin
        file_count <= file_count + 1'b1;
      end
      if (exec_load) begin
        case (cur_op.kind)
          OP_BYTE: write_offset <= wo_inc;
          OP_END: begin
            next_offset <= write_offset;
            file_open   <= 1'b0;
          end
          default: write_offset <= write_offset;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (!empty) begin
            op_r <= head;
            q_r  <= head.query[OFFSET_BITS-1:0];
            case (head.kind)
              OP_QUERY: begin
                flo <= '0;
                fhi <= file_count;
                if (!head.loc_valid) begin
                  status_r <= ST_INVALID;
                  state    <= S_DONE;
                end else if (file_count == '0) begin
                  status_r <= ST_OUTSIDE;
                  state    <= S_DONE;
                end else begin
                  state <= S_FSRCH;
                end
              end
              default: begin
                if (!file_open) begin
                  state <= S_OPEN;
                end
              end
            endcase
          end
        end
        S_OPEN: begin
          file_open    <= 1'b1;
          write_offset <= next_offset;
          state        <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_IDLE;
        end
        S_FSRCH: begin
          flo <= flo_n;
          fhi <= fhi_n;
          if (!f_more) begin
            f_r <= flo_n;
            if (flo_n >= file_count) begin
              status_r <= ST_OUTSIDE;
              state    <= S_DONE;
            end else begin
              state <= S_FCHK;
            end
          end
        end
        S_FCHK: begin
          if (q_r < fs_rdata) begin
            status_r <= ST_OUTSIDE;
            state    <= S_DONE;
          end else begin
            ls_r    <= fs_rdata;
            a_r     <= ffl_rdata;
            use_cnt <= !(f_p1 < file_count) && !(file_open && fc_room);
            state   <= S_FB;
          end
        end
        S_FB: begin
          if (b_eff == a_r) begin
            line_r   <= LCNT_W'(1);
            status_r <= ST_FOUND;
            state    <= S_DONE;
          end else begin
            l2    <= a_r;
            h2    <= b_eff;
            state <= S_LSRCH;
          end
        end
        S_LSRCH: begin
          l2 <= l2_n;
          h2 <= h2_n;
          if (!l_more) begin
            if (l2_n == a_r) begin
              line_r   <= LCNT_W'(1);
              status_r <= ST_FOUND;
              state    <= S_DONE;
            end else begin
              line_r <= l2_n - a_r;
              state  <= S_LFIN;
            end
          end
        end
        S_LFIN: begin
          ls_r     <= ls_rdata;
          status_r <= ST_FOUND;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_status <= status_r;
            out_ovf    <= overflow;
            if (status_r == ST_FOUND) begin
              out_file <= FIDX_W'(f_r);
              out_line <= LINE_W'(line_r);
              out_col  <= COL_W'(col_diff) + 1'b1;
            end else begin
              out_file <= '0;
              out_line <= '0;
              out_col  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // first offset write moves the load point only before any file exists
      if (cfg.valid && (file_count == '0) && !file_open) begin
        next_offset <= cfg.data[OFFSET_BITS-1:0];
      end
    end
  end

  // result channel
  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.file_index     = out_file;
  assign result.line_number    = out_line;
  assign result.column_number  = out_col;
  assign result.table_overflow = out_ovf;

  // file start offsets
  sol_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_FILES)) u_file_start (
    .clk   (clk),
    .we    (fs_we),
    .waddr (f_waddr),
    .wdata (next_offset),
    .raddr (f_raddr),
    .rdata (fs_rdata)
  );

  // file end offsets
  sol_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_FILES)) u_file_end (
    .clk   (clk),
    .we    (fe_we),
    .waddr (f_waddr),
    .wdata (write_offset),
    .raddr (f_raddr),
    .rdata (fe_rdata)
  );

  // first line table index of each file
  sol_ram #(.WIDTH(LCNT_W), .DEPTH(MAX_FILES)) u_file_first_line (
    .clk   (clk),
    .we    (ffl_we),
    .waddr (f_waddr),
    .wdata (line_count),
    .raddr (ffl_raddr),
    .rdata (ffl_rdata)
  );

  // global line start offsets
  sol_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_LINES)) u_line_start (
    .clk   (clk),
    .we    (ls_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (ls_rdata)
  );
endmodule

/* design/source_offset_line_locator.sv */
// Source offset line locator, top level.
// The item channel takes content bytes, end-of-file markers and location queries;
// the result channel returns one beat per query (status, file, line, column and
// the sticky overflow flag); the cfg channel writes the first file offset and is
// always ready. Items pass a four-entry queue to the execution sequencer, so the
// item channel keeps accepting while a query is being searched or a result stalls,
// until the queue is full. A byte or end marker is applied as it leaves the queue
// when a file is open; otherwise the sequencer first passes its open and load states.
// A query runs a binary search over the file end ram and then one over the line
// start ram of that file, one probe per registered read, plus check and final steps.
// An invalid location skips both searches and goes straight to the result state.
// Tables need no clearing: reset zeroes the file and line counts, the offsets, the
// open flag and the overflow flag, and the block is ready in the cycle after reset.
// A stalled result holds in its output register; the sequencer then waits with
// the next query, while the queue keeps filling.
`timescale 1ns / 1ps
module source_offset_line_locator #(
  parameter int MAX_FILES   = sol_pkg::MAX_FILES_DEF,
  parameter int MAX_LINES   = sol_pkg::MAX_LINES_DEF,
  parameter int OFFSET_BITS = sol_pkg::OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sol_item_if.sink     item,
  sol_result_if.source result,
  sol_cfg_if.sink      cfg
);
  import sol_pkg::*;

  logic push;
  op_t  push_op;
  logic full;
  logic pop;
  op_t  head;
  logic empty;

  // decode and accept
  sol_front u_front (
    .item    (item),
    .push    (push),
    .push_op (push_op),
    .full    (full)
  );

  // decoupling queue
  sol_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .head    (head),
    .empty   (empty)
  );

  // execution
  sol_back #(
    .MAX_FILES   (MAX_FILES),
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );
endmodule
